/* design/formula_lexer_macros.svh */
// Assertion macros shared by the formula lexer modules.
// Users must have signals named clock and reset in scope.
`ifndef FORMULA_LEXER_MACROS_SVH
`define FORMULA_LEXER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked outside reset.
`define FLEX_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked at every edge, reset included.
`define FLEX_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define FLEX_ASSERT(label, prop, msg)
`define FLEX_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* design/flex_pkg.sv */
// Types, codes and byte-class functions of the formula lexer.
// Used by every module of the block; depends on nothing.
package flex_pkg;

   localparam int unsigned LENGTH_BITS_DEFAULT = 16;
   localparam int unsigned PREFIX_DEPTH = 9;
   localparam int unsigned PFX_IDX_BITS = $clog2(PREFIX_DEPTH);
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE_TOP = 8'h20;
   localparam logic [7:0] CH_HIGH_FIRST = 8'h80;

   localparam logic [3:0] KIND_OP = 4'd0;
   localparam logic [3:0] KIND_IDENT = 4'd1;
   localparam logic [3:0] KIND_INT = 4'd2;
   localparam logic [3:0] KIND_DEC = 4'd3;
   localparam logic [3:0] KIND_LSQ = 4'd4;
   localparam logic [3:0] KIND_RSQ = 4'd5;
   localparam logic [3:0] KIND_LPAR = 4'd6;
   localparam logic [3:0] KIND_RPAR = 4'd7;
   localparam logic [3:0] KIND_COMMA = 4'd8;
   localparam logic [3:0] KIND_SEMI = 4'd9;
   localparam logic [3:0] KIND_WS = 4'd10;
   localparam logic [3:0] KIND_EOL = 4'd11;
   localparam logic [3:0] KIND_KW = 4'd12;
   localparam logic [3:0] KIND_STR = 4'd13;
   localparam logic [3:0] KIND_CMT = 4'd14;
   localparam logic [3:0] KIND_PTR = 4'd15;

   localparam logic [2:0] ERR_NONE = 3'd0;
   localparam logic [2:0] ERR_DOTS = 3'd1;
   localparam logic [2:0] ERR_STRING = 3'd2;
   localparam logic [2:0] ERR_COMMENT = 3'd3;
   localparam logic [2:0] ERR_UNKNOWN = 3'd4;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_SPACE,
      MODE_STRING,
      MODE_COMMENT,
      MODE_LT,
      MODE_GT,
      MODE_MINUS,
      MODE_DOT,
      MODE_BANG
   } mode_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [15:0] token_length;
      logic [2:0]  error_code;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } tok_type;

   // Everything one byte produces: one or two tokens.
   typedef struct packed {
      logic    second_valid;
      rsp_type first;
      rsp_type second;
   } pair_type;

   typedef logic [PREFIX_DEPTH-1:0][7:0] prefix_type;

   function automatic logic is_word(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c <= CH_SPACE_TOP && c != CH_NEWLINE) || c >= CH_HIGH_FIRST;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic tok_type make_tok(input logic [3:0] kind, input logic [15:0] length,
                                        input logic [2:0] err);
      tok_type t;
      t.valid = 1'b1;
      t.rsp.token_kind = kind;
      t.rsp.token_length = length;
      t.rsp.error_code = err;
      t.rsp.last_of_run = 1'b0;
      return t;
   endfunction

   // Classifies a finished word; fits is low when the run is longer than the prefix.
   function automatic logic [3:0] word_kind(input prefix_type p,
                                            input logic [PFX_IDX_BITS-1:0] len,
                                            input logic fits);
      logic is_op;
      logic is_kw;
      is_op = (len == 4'd1 && p[0] == "d")
           || (len == 4'd2 && {p[0], p[1]} == "or")
           || (len == 4'd3 && {p[0], p[1], p[2]} == "and")
           || (len == 4'd3 && {p[0], p[1], p[2]} == "not")
           || (len == 4'd5 && {p[0], p[1], p[2], p[3], p[4]} == "where");
      is_kw = (len == 4'd3 && {p[0], p[1], p[2]} == "def")
           || (len == 4'd3 && {p[0], p[1], p[2]} == "fai")
           || (len == 4'd6 && {p[0], p[1], p[2], p[3], p[4], p[5]} == "faiend")
           || (len == 4'd9
               && {p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8]} == "functions");
      if (fits && is_op) begin
         return KIND_OP;
      end else if (fits && is_kw) begin
         return KIND_KW;
      end
      return KIND_IDENT;
   endfunction

endpackage

/* design/flex_front.sv */
// Front end of the formula lexer: accepts bytes, tracks the pending token
// and writes the tokens of each byte into the queue. Depends on flex_pkg.
`include "formula_lexer_macros.svh"
module flex_front import flex_pkg::*; #(
   parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid_i,
   input  req_type  req_i,
   input  logic     full_i,
   output logic     push_o,
   output pair_type entry_o
);

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

   mode_type               mode_ff, mode_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic                   dot_ff, dot_in;
   prefix_type             prefix_ff, prefix_in;

   logic                   accept;
   logic [7:0]             c;
   logic [LENGTH_BITS-1:0] len_inc;
   tok_type                tok_a, tok_b, tok_c, tok_first, tok_second;
   logic                   restart;
   mode_type               mode_a, mode_b;
   logic [LENGTH_BITS-1:0] len_a, len_b;
   logic                   dot_a, dot_b;
   prefix_type             pfx_a, pfx_b;

   assign accept  = req_valid_i && !full_i;
   assign c       = req_i.char_in;
   assign len_inc = (len_ff == LEN_MAX) ? len_ff : len_ff + 1'b1;

   always_comb begin
      tok_a   = '0;
      tok_b   = '0;
      tok_c   = '0;
      restart = 1'b0;
      mode_a  = mode_ff;
      len_a   = len_ff;
      dot_a   = dot_ff;
      pfx_a   = prefix_ff;

      // The byte against the pending token.
      unique case (mode_ff)
         MODE_IDENT: begin
            if (is_word(c)) begin
               if (len_ff <= LENGTH_BITS'(PREFIX_DEPTH - 1)) begin
                  pfx_a[len_ff[PFX_IDX_BITS-1:0]] = c;
               end
               len_a = len_inc;
            end else begin
               tok_a = make_tok(word_kind(prefix_ff, len_ff[PFX_IDX_BITS-1:0],
                                          len_ff <= LENGTH_BITS'(PREFIX_DEPTH)),
                                16'(len_ff), ERR_NONE);
               restart = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (is_digit(c)) begin
               len_a = len_inc;
            end else if (c == ".") begin
               if (dot_ff) begin
                  tok_a  = make_tok(KIND_OP, 16'd0, ERR_DOTS);
                  mode_a = MODE_IDLE;
                  len_a  = '0;
                  dot_a  = 1'b0;
               end else begin
                  dot_a = 1'b1;
                  len_a = len_inc;
               end
            end else begin
               tok_a   = make_tok(dot_ff ? KIND_DEC : KIND_INT, 16'(len_ff), ERR_NONE);
               restart = 1'b1;
            end
         end
         MODE_SPACE: begin
            if (is_space(c)) begin
               len_a = len_inc;
            end else begin
               tok_a   = make_tok(KIND_WS, 16'(len_ff), ERR_NONE);
               restart = 1'b1;
            end
         end
         MODE_STRING, MODE_COMMENT: begin
            len_a = len_inc;
            if ((mode_ff == MODE_STRING && c == "'") ||
                (mode_ff == MODE_COMMENT && c == "#")) begin
               tok_a  = make_tok(mode_ff == MODE_STRING ? KIND_STR : KIND_CMT,
                                 16'(len_inc), ERR_NONE);
               mode_a = MODE_IDLE;
               len_a  = '0;
            end
         end
         MODE_LT, MODE_GT, MODE_BANG: begin
            if (c == "=") begin
               tok_a  = make_tok(KIND_OP, 16'd2, ERR_NONE);
               mode_a = MODE_IDLE;
               len_a  = '0;
            end else if (mode_ff == MODE_BANG) begin
               // A bang that is not part of != takes the next byte with it.
               tok_a  = make_tok(KIND_OP, 16'd0, ERR_UNKNOWN);
               mode_a = MODE_IDLE;
               len_a  = '0;
            end else begin
               tok_a   = make_tok(KIND_OP, 16'd1, ERR_NONE);
               restart = 1'b1;
            end
         end
         MODE_MINUS: begin
            if (c == ">") begin
               tok_a  = make_tok(KIND_PTR, 16'd2, ERR_NONE);
               mode_a = MODE_IDLE;
               len_a  = '0;
            end else begin
               tok_a   = make_tok(KIND_OP, 16'd1, ERR_NONE);
               restart = 1'b1;
            end
         end
         MODE_DOT: begin
            if (c == "+" || c == "-" || c == "*" || c == "/") begin
               tok_a  = make_tok(KIND_OP, 16'd2, ERR_NONE);
               mode_a = MODE_IDLE;
               len_a  = '0;
            end else begin
               tok_a   = make_tok(KIND_OP, 16'd1, ERR_NONE);
               restart = 1'b1;
            end
         end
         default: begin
            restart = 1'b1;
         end
      endcase

      // The byte as the first of a new token.
      mode_b = mode_a;
      len_b  = len_a;
      dot_b  = dot_a;
      pfx_b  = pfx_a;
      if (restart) begin
         mode_b = MODE_IDLE;
         len_b  = LENGTH_BITS'(1);
         dot_b  = 1'b0;
         if (c == CH_NEWLINE) begin
            tok_b = make_tok(KIND_EOL, 16'd1, ERR_NONE);
            len_b = '0;
         end else if (is_space(c)) begin
            mode_b = MODE_SPACE;
         end else if (is_word(c)) begin
            mode_b   = MODE_IDENT;
            pfx_b[0] = c;
         end else if (is_digit(c)) begin
            mode_b = MODE_NUMBER;
         end else if (c == "'") begin
            mode_b = MODE_STRING;
         end else if (c == "#") begin
            mode_b = MODE_COMMENT;
         end else if (c == "<") begin
            mode_b = MODE_LT;
         end else if (c == ">") begin
            mode_b = MODE_GT;
         end else if (c == "-") begin
            mode_b = MODE_MINUS;
         end else if (c == ".") begin
            mode_b = MODE_DOT;
         end else if (c == "!") begin
            mode_b = MODE_BANG;
         end else begin
            len_b = '0;
            unique case (c) inside
               "[":                          tok_b = make_tok(KIND_LSQ, 16'd1, ERR_NONE);
               "]":                          tok_b = make_tok(KIND_RSQ, 16'd1, ERR_NONE);
               "(":                          tok_b = make_tok(KIND_LPAR, 16'd1, ERR_NONE);
               ")":                          tok_b = make_tok(KIND_RPAR, 16'd1, ERR_NONE);
               ",":                          tok_b = make_tok(KIND_COMMA, 16'd1, ERR_NONE);
               ";":                          tok_b = make_tok(KIND_SEMI, 16'd1, ERR_NONE);
               "^", "=", "+", "*", "/", "%": tok_b = make_tok(KIND_OP, 16'd1, ERR_NONE);
               default:                      tok_b = make_tok(KIND_OP, 16'd0, ERR_UNKNOWN);
            endcase
         end
      end

      // End of input flushes whatever is still pending.
      mode_in   = mode_b;
      len_in    = len_b;
      dot_in    = dot_b;
      prefix_in = pfx_b;
      if (req_i.end_of_input) begin
         unique case (mode_b)
            MODE_IDENT:   tok_c = make_tok(word_kind(pfx_b, len_b[PFX_IDX_BITS-1:0],
                                                     len_b <= LENGTH_BITS'(PREFIX_DEPTH)),
                                           16'(len_b), ERR_NONE);
            MODE_NUMBER:  tok_c = make_tok(dot_b ? KIND_DEC : KIND_INT, 16'(len_b), ERR_NONE);
            MODE_SPACE:   tok_c = make_tok(KIND_WS, 16'(len_b), ERR_NONE);
            MODE_STRING:  tok_c = make_tok(KIND_OP, 16'd0, ERR_STRING);
            MODE_COMMENT: tok_c = make_tok(KIND_OP, 16'd0, ERR_COMMENT);
            MODE_BANG:    tok_c = make_tok(KIND_OP, 16'd0, ERR_UNKNOWN);
            MODE_LT, MODE_GT, MODE_MINUS, MODE_DOT:
                          tok_c = make_tok(KIND_OP, 16'd1, ERR_NONE);
            default:      tok_c = '0;
         endcase
         mode_in = MODE_IDLE;
         len_in  = '0;
         dot_in  = 1'b0;
      end

      // At most two of the three tokens are ever present.
      if (tok_a.valid) begin
         tok_first  = tok_a;
         tok_second = tok_b.valid ? tok_b : tok_c;
      end else begin
         tok_first  = tok_b.valid ? tok_b : tok_c;
         tok_second = '0;
      end
   end

   always_comb begin
      entry_o.second_valid          = tok_second.valid;
      entry_o.first                 = tok_first.rsp;
      entry_o.first.last_of_run     = !tok_second.valid;
      entry_o.second                = tok_second.rsp;
      entry_o.second.last_of_run    = 1'b1;
      push_o                        = accept && tok_first.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         len_ff  <= '0;
         dot_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
         dot_ff  <= dot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prefix_ff <= prefix_in;
      end
   end

   `FLEX_ASSERT(a_idle_after_end, (accept && req_i.end_of_input) |=> (mode_ff == MODE_IDLE && len_ff == '0), "lexer not idle after end of input")
   `FLEX_ASSERT(a_error_is_last, (push_o && entry_o.first.error_code != ERR_NONE) |-> !entry_o.second_valid, "token follows an error from the same item")

endmodule

/* design/flex_queue.sv */
// Short queue between the lexer front end and the output stage.
// Holds one entry per item with tokens. Depends on flex_pkg.
`include "formula_lexer_macros.svh"
module flex_queue import flex_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_i,
   input  pair_type entry_i,
   input  logic     pop_i,
   output pair_type head_o,
   output logic     empty_o,
   output logic     full_o
);

   // The pointers wrap naturally, so the depth is a power of two.
   localparam int unsigned PTR_BITS = $clog2(QUEUE_DEPTH);

   pair_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]   count_ff, count_in;

   assign empty_o = (count_ff == '0);
   assign full_o  = (count_ff == (PTR_BITS + 1)'(QUEUE_DEPTH));
   assign head_o  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_i ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_i ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_i && !pop_i) begin
         count_in = count_ff + 1'b1;
      end else if (pop_i && !push_i) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         entry_ff[wr_ptr_ff] <= entry_i;
      end
   end

   `FLEX_ASSERT(a_no_overflow, push_i |-> !full_o, "push into a full queue")
   `FLEX_ASSERT(a_no_underflow, pop_i |-> !empty_o, "pop from an empty queue")
   `FLEX_ASSERT_ALWAYS(a_reset_empties, reset |=> (count_ff == '0), "queue not empty after reset")

endmodule

/* design/flex_back.sv */
// Output stage of the formula lexer: takes queue entries and hands out
// their one or two tokens in order. Depends on flex_pkg.
`include "formula_lexer_macros.svh"
module flex_back import flex_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  pair_type head_i,
   input  logic     empty_i,
   output logic     pop_o,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   pair_type cur_ff, cur_in;
   logic     cur_valid_ff, cur_valid_in;
   logic     second_ff, second_in;
   logic     fire;
   logic     done;

   assign rsp_valid = cur_valid_ff;
   assign rsp_data  = second_ff ? cur_ff.second : cur_ff.first;
   assign fire      = cur_valid_ff && !rsp_stall;
   assign done      = fire && (second_ff || !cur_ff.second_valid);
   assign pop_o     = !empty_i && (!cur_valid_ff || done);

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      second_in    = second_ff;
      if (pop_o) begin
         cur_in       = head_i;
         cur_valid_in = 1'b1;
         second_in    = 1'b0;
      end else if (done) begin
         cur_valid_in = 1'b0;
         second_in    = 1'b0;
      end else if (fire) begin
         second_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   `FLEX_ASSERT(a_second_needs_pair, second_ff |-> (cur_valid_ff && cur_ff.second_valid), "second token shown without a pair")

endmodule

/* design/formula_lexer.sv */
// Formula lexer: one source byte per item in, tokens as kind and length out.
// A completed token is written into the queue and then the output register before
// it is offered. Throughput: one byte per cycle while the queue is not full;
// a byte that yields two tokens holds the output port for both of them, and the
// two-entry queue absorbs that before bytes stall.
// Reset clears the lexer mode, run length, dot flag, queue count and output valid flags.
module formula_lexer import flex_pkg::*; #(
   parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic     push;
   logic     pop;
   logic     empty;
   logic     full;
   pair_type entry;
   pair_type head;

   assign req_stall = full;

   flex_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid_i(req_valid),
      .req_i      (req_data),
      .full_i     (full),
      .push_o     (push),
      .entry_o    (entry)
   );

   flex_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push_i (push),
      .entry_i(entry),
      .pop_i  (pop),
      .head_o (head),
      .empty_o(empty),
      .full_o (full)
   );

   flex_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_i   (head),
      .empty_i  (empty),
      .pop_o    (pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule
